/* hw/rtl/csm_pkg.sv */
`timescale 1ns / 1ps

package csm_pkg;

  // Shared divider: 64-bit dividend, 32-bit divisor, one quotient bit per cycle.
  localparam int unsigned DivSteps    = 64;
  localparam int unsigned DivCntWidth = $clog2(DivSteps);

  localparam logic [15:0] WindowLengthReset = 16'd60;

  // Command codes carried by the input beat.
  localparam logic CmdRecord = 1'b0;
  localparam logic CmdReport = 1'b1;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

/* hw/rtl/csm_ram.sv */
`timescale 1ns / 1ps

module csm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/csm_div.sv */
`timescale 1ns / 1ps

module csm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csm_pkg::div_req_t req_i,
  output csm_pkg::div_rsp_t rsp_o
);
  import csm_pkg::*;

  logic [63:0]            acc_q;
  logic [31:0]            rem_q;
  logic [31:0]            dsr_q;
  logic [DivCntWidth-1:0] cnt_q;
  logic                   busy_q;
  logic                   done_q;
  logic [32:0]            trial;
  logic [32:0]            diff;
  logic                   fits;

  // One restoring step: shift in the next dividend bit and try the subtraction.
  always_comb begin
    trial = {rem_q, acc_q[63]};
    diff  = trial - {1'b0, dsr_q};
    fits  = !diff[32];
  end

  // The dividend register fills with quotient bits from the bottom as it empties.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntWidth'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      acc_q <= {acc_q[62:0], fits};
      rem_q <= fits ? diff[31:0] : trial[31:0];
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = acc_q;
  assign rsp_o.rem  = rem_q;

endmodule

/* hw/rtl/completion_stats_monitor.sv */
`timescale 1ns / 1ps
// Record beat: from acceptance to ready again it takes two divisions on the shared
// divider, then a histogram read-modify-write; a zero job time skips the first.
// Report beat: a histogram scan, StScanA then StScanB for each window, then three
// divisions to a valid result, or straight to it when nothing was recorded.
// One beat is in flight at a time and the result holds until taken. Reset clears all
// statistics and runs a histogram clearing pass, during which no beat is accepted.
module completion_stats_monitor #(
  parameter int unsigned WINDOWS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] current_time_i,
  input  logic [31:0] arrival_time_i,
  input  logic [31:0] job_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] throughput_avg_o,
  output logic [15:0] throughput_min_o,
  output logic [15:0] throughput_max_o,
  output logic [31:0] turnaround_avg_o,
  output logic [31:0] overhead_max_o,
  output logic [31:0] overhead_avg_o,
  output logic [31:0] makespan_o,
  output logic        no_data_o
);
  import csm_pkg::*;

  localparam int unsigned IW = $clog2(WINDOWS);
  localparam int unsigned TW = 17 + IW;

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StRatio = 4'd2;
  localparam logic [3:0] StIdx   = 4'd3;
  localparam logic [3:0] StHRd   = 4'd4;
  localparam logic [3:0] StHWr   = 4'd5;
  localparam logic [3:0] StScanA = 4'd6;
  localparam logic [3:0] StScanB = 4'd7;
  localparam logic [3:0] StAvg   = 4'd8;
  localparam logic [3:0] StTa    = 4'd9;
  localparam logic [3:0] StOv    = 4'd10;
  localparam logic [3:0] StOut   = 4'd11;

  logic [3:0]    state_q, state_d;
  logic [15:0]   wl_q;
  logic [15:0]   len_eff;
  logic [31:0]   cnt_q;
  logic [63:0]   ta_sum_q;
  logic [63:0]   ov_sum_q;
  logic [31:0]   ov_peak_q;
  logic          zero_job_q;
  logic [31:0]   now_q;
  logic [IW-1:0] idx_q;
  logic [IW-1:0] scan_q;
  logic [IW-1:0] clr_q;
  logic [TW-1:0] total_q;
  logic [IW-1:0] last_q;
  logic [15:0]   tmin_q;
  logic [15:0]   tmax_q;
  logic          seen_q;
  logic [15:0]   res_tavg_q;
  logic [31:0]   res_ta_q;
  logic [31:0]   res_ov_q;
  logic          no_data_q;

  logic          in_acc;
  logic [31:0]   turn_c;
  logic [64:0]   ta_add;
  logic [31:0]   ratio_c;
  logic [64:0]   ov_add;
  logic [64:0]   ta_round;
  logic [TW-1:0] total_n;
  logic [IW-1:0] last_n;
  logic [15:0]   tmin_n;
  logic [15:0]   tmax_n;
  logic          seen_n;
  logic [15:0]   hist_rdata;
  logic          hist_we;
  logic [IW-1:0] hist_waddr;
  logic [IW-1:0] hist_raddr;
  logic [15:0]   hist_wdata;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign len_eff    = (wl_q == 16'd0) ? 16'd1 : wl_q;

  // Per-record arithmetic: turnaround, saturating sums, clamped ratio.
  always_comb begin
    turn_c = (arrival_time_i > current_time_i) ? 32'd0 : current_time_i - arrival_time_i;
    ta_add = {1'b0, ta_sum_q} + {33'd0, turn_c};
    if (zero_job_q || (div_rsp.quot[63:32] != 32'd0)) begin
      ratio_c = '1;
    end else begin
      ratio_c = div_rsp.quot[31:0];
    end
    ov_add   = {1'b0, ov_sum_q} + {33'd0, ratio_c};
    ta_round = {1'b0, div_rsp.quot} + {64'd0, (div_rsp.rem != 32'd0)};
  end

  // Scan step over one histogram entry.
  always_comb begin
    total_n = total_q + TW'(hist_rdata);
    last_n  = last_q;
    tmin_n  = tmin_q;
    seen_n  = seen_q;
    tmax_n  = (hist_rdata > tmax_q) ? hist_rdata : tmax_q;
    if (hist_rdata == 16'd0) begin
      seen_n = 1'b1;
    end else begin
      last_n = scan_q;
      if (seen_q) begin
        tmin_n = 16'd0;
      end else if (hist_rdata < tmin_q) begin
        tmin_n = hist_rdata;
      end
    end
  end

  // Divider requests, issued on the edge that leaves each step.
  always_comb begin
    div_req = '0;
    unique case (state_q)
      StIdle: begin
        if (in_acc && (cmd_i == CmdRecord) && (job_time_i != 32'd0)) begin
          div_req.start    = 1'b1;
          div_req.dividend = {16'd0, turn_c, 16'd0};
          div_req.divisor  = job_time_i;
        end
      end
      StRatio: begin
        if (zero_job_q || div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = (now_q == 32'd0) ? 64'd0 : {32'd0, now_q - 32'd1};
          div_req.divisor  = {16'd0, len_eff};
        end
      end
      StScanB: begin
        if (scan_q == IW'(WINDOWS - 1)) begin
          div_req.start    = 1'b1;
          div_req.dividend = 64'(total_n) + 64'(last_n);
          div_req.divisor  = 32'(last_n) + 32'd1;
        end
      end
      StAvg: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = ta_sum_q;
          div_req.divisor  = cnt_q;
        end
      end
      StTa: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = ov_sum_q;
          div_req.divisor  = cnt_q;
        end
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_q == IW'(WINDOWS - 1)) state_d = StIdle;
      StIdle: begin
        if (in_acc) begin
          if (cmd_i == CmdRecord) begin
            state_d = StRatio;
          end else if (cnt_q == 32'd0) begin
            state_d = StOut;
          end else begin
            state_d = StScanA;
          end
        end
      end
      StRatio: if (zero_job_q || div_rsp.done) state_d = StIdx;
      StIdx:   if (div_rsp.done) state_d = StHRd;
      StHRd:   state_d = StHWr;
      StHWr:   state_d = StIdle;
      StScanA: state_d = StScanB;
      StScanB: state_d = (scan_q == IW'(WINDOWS - 1)) ? StAvg : StScanA;
      StAvg:   if (div_rsp.done) state_d = StTa;
      StTa:    if (div_rsp.done) state_d = StOv;
      StOv:    if (div_rsp.done) state_d = StOut;
      StOut:   if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Histogram memory port selection.
  always_comb begin
    hist_we    = (state_q == StClear) || (state_q == StHWr);
    hist_waddr = (state_q == StClear) ? clr_q : idx_q;
    hist_raddr = (state_q == StHRd) ? idx_q : scan_q;
    if (state_q == StClear) begin
      hist_wdata = 16'd0;
    end else if (hist_rdata == 16'hFFFF) begin
      hist_wdata = hist_rdata;
    end else begin
      hist_wdata = hist_rdata + 16'd1;
    end
  end

  // Control and statistics registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      wl_q      <= WindowLengthReset;
      cnt_q     <= '0;
      ta_sum_q  <= '0;
      ov_sum_q  <= '0;
      ov_peak_q <= '0;
      clr_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        wl_q <= cfg_wdata_i;
      end
      if (state_q == StClear) begin
        clr_q <= clr_q + 1'b1;
      end
      if (in_acc && (cmd_i == CmdRecord)) begin
        ta_sum_q <= ta_add[64] ? '1 : ta_add[63:0];
      end
      if ((state_q == StRatio) && (zero_job_q || div_rsp.done)) begin
        ov_sum_q <= ov_add[64] ? '1 : ov_add[63:0];
        if (ratio_c > ov_peak_q) begin
          ov_peak_q <= ratio_c;
        end
      end
      if ((state_q == StHWr) && (cnt_q != '1)) begin
        cnt_q <= cnt_q + 32'd1;
      end
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q      <= current_time_i;
      zero_job_q <= (job_time_i == 32'd0);
      no_data_q  <= (cmd_i == CmdReport) && (cnt_q == 32'd0);
      scan_q     <= '0;
      total_q    <= '0;
      last_q     <= '0;
      tmin_q     <= '1;
      tmax_q     <= '0;
      seen_q     <= 1'b0;
    end
    if ((state_q == StIdx) && div_rsp.done) begin
      idx_q <= (div_rsp.quot > 64'(WINDOWS - 1)) ? IW'(WINDOWS - 1) : div_rsp.quot[IW-1:0];
    end
    if (state_q == StScanB) begin
      total_q <= total_n;
      last_q  <= last_n;
      tmin_q  <= tmin_n;
      tmax_q  <= tmax_n;
      seen_q  <= seen_n;
      scan_q  <= scan_q + 1'b1;
    end
    if ((state_q == StAvg) && div_rsp.done) begin
      res_tavg_q <= div_rsp.quot[15:0];
    end
    if ((state_q == StTa) && div_rsp.done) begin
      res_ta_q <= (ta_round[64:32] != 33'd0) ? '1 : ta_round[31:0];
    end
    if ((state_q == StOv) && div_rsp.done) begin
      res_ov_q <= (div_rsp.quot[63:32] != 32'd0) ? '1 : div_rsp.quot[31:0];
    end
  end

  csm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  csm_ram #(
    .Width (16),
    .Depth (WINDOWS)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // Result beat; every field but the flag reads zero when nothing was recorded.
  assign out_valid_o      = (state_q == StOut);
  assign no_data_o        = no_data_q;
  assign throughput_avg_o = no_data_q ? 16'd0 : res_tavg_q;
  assign throughput_min_o = no_data_q ? 16'd0 : tmin_q;
  assign throughput_max_o = no_data_q ? 16'd0 : tmax_q;
  assign turnaround_avg_o = no_data_q ? 32'd0 : res_ta_q;
  assign overhead_max_o   = no_data_q ? 32'd0 : ov_peak_q;
  assign overhead_avg_o   = no_data_q ? 32'd0 : res_ov_q;
  assign makespan_o       = no_data_q ? 32'd0 : now_q;

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy) else $error("divider restarted while busy");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o) else $error("ready again straight after a beat");

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> !in_ready_o && !out_valid_o)
    else $error("channel active during clearing pass");

  a_result_not_with_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !div_rsp.busy) else $error("result shown while dividing");

endmodule

/* tb/completion_stats_monitor_tb.sv */
`timescale 1ns / 1ps

module completion_stats_monitor_tb;
  import csm_pkg::*;

  localparam int unsigned Windows     = 256;
  localparam int unsigned SettleCycles = 2 * Windows + 400;
  localparam int unsigned WatchLimit   = 40000;
  localparam int unsigned RandomBeats  = 1330;

  typedef struct packed {
    logic [15:0] tput_avg;
    logic [15:0] tput_min;
    logic [15:0] tput_max;
    logic [31:0] turn_avg;
    logic [31:0] ovh_max;
    logic [31:0] ovh_avg;
    logic [31:0] makespan;
    logic        no_data;
  } report_t;

  typedef struct {
    logic        cmd;
    logic [31:0] now;
    logic [31:0] arrived;
    logic [31:0] job;
    logic        typed;
    report_t     want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i = CmdRecord;
  logic [31:0] current_time_i = '0;
  logic [31:0] arrival_time_i = '0;
  logic [31:0] job_time_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  report_t     got;

  completion_stats_monitor #(.WINDOWS(Windows)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .cmd_i, .current_time_i, .arrival_time_i, .job_time_i,
    .out_valid_o, .out_ready_i,
    .throughput_avg_o(got.tput_avg), .throughput_min_o(got.tput_min),
    .throughput_max_o(got.tput_max), .turnaround_avg_o(got.turn_avg),
    .overhead_max_o(got.ovh_max), .overhead_avg_o(got.ovh_avg),
    .makespan_o(got.makespan), .no_data_o(got.no_data)
  );

  always #6 clk_i = ~clk_i;

  // Shadow statistics state.
  logic [15:0] win_len;
  logic [15:0] win_hist [Windows];
  logic [63:0] turn_total;
  logic [63:0] ovh_total;
  logic [31:0] ovh_peak;
  logic [31:0] done_count;

  report_t report_queue [$];
  int      fail_count = 0;
  int      watch = 0;
  bit      calm = 1'b0;

  function automatic logic [31:0] sat32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  task automatic record_completion(logic [31:0] now, logic [31:0] arrived,
                                   logic [31:0] job);
    logic [31:0] turn;
    logic [31:0] ratio;
    logic [31:0] len;
    logic [31:0] idx;
    turn = (arrived > now) ? 32'd0 : now - arrived;
    turn_total = sat_add(turn_total, {32'd0, turn});
    ratio = (job == 0) ? 32'hFFFF_FFFF : sat32({16'd0, turn, 16'd0} / {32'd0, job});
    ovh_total = sat_add(ovh_total, {32'd0, ratio});
    if (ratio > ovh_peak) ovh_peak = ratio;
    len = (win_len == 0) ? 32'd1 : {16'd0, win_len};
    idx = (now == 0) ? 32'd0 : (now - 1) / len;
    if (idx > Windows - 1) idx = Windows - 1;
    if (win_hist[idx] != 16'hFFFF) win_hist[idx]++;
    if (done_count != 32'hFFFF_FFFF) done_count++;
  endtask

  function automatic report_t predict_report(logic [31:0] now);
    report_t r;
    logic [63:0] total;
    logic [63:0] q;
    logic [31:0] last;
    logic [31:0] tmin;
    logic [31:0] tmax;
    bit          gap;
    r = '0;
    if (done_count == 0) begin
      r.no_data = 1'b1;
      return r;
    end
    total = 0; last = 0; tmin = 32'hFFFF_FFFF; tmax = 0; gap = 1'b0;
    for (int i = 0; i < Windows; i++) begin
      if (win_hist[i] == 0) begin
        gap = 1'b1;
      end else begin
        last = i;
        if (gap) tmin = 0;
        else if (win_hist[i] < tmin) tmin = win_hist[i];
      end
      if (win_hist[i] > tmax) tmax = win_hist[i];
      total += win_hist[i];
    end
    q = (total + last) / ({32'd0, last} + 1);
    r.tput_avg = q[15:0];
    r.tput_min = tmin[15:0];
    r.tput_max = tmax[15:0];
    q = turn_total / done_count;
    if (turn_total % done_count != 0) q++;
    r.turn_avg = sat32(q);
    r.ovh_max = ovh_peak;
    r.ovh_avg = sat32(ovh_total / done_count);
    r.makespan = now;
    return r;
  endfunction

  // Apply one input beat and wait for its acceptance; the prediction is queued
  // at acceptance so the shadow state follows the order the block sees. Valid
  // stays high into the next beat unless an idle gap or a pause follows.
  task automatic send_beat(logic cmd, logic [31:0] now, logic [31:0] arrived,
                           logic [31:0] job, logic typed, report_t want);
    report_t r;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= cmd;
    current_time_i <= now;
    arrival_time_i <= arrived;
    job_time_i     <= job;
    do @(posedge clk_i); while (!in_ready_o);
    if (cmd == CmdReport) begin
      r = predict_report(now);
      if (typed && r != want) begin
        fail_count++;
        if (fail_count <= 10)
          $display("typed row disagrees with prediction: typed %h predicted %h", want, r);
      end
      report_queue.push_back(r);
    end else begin
      record_completion(now, arrived, job);
    end
    @(negedge clk_i);
  endtask

  task automatic drain_and_write(logic [15:0] len);
    in_valid_i <= 1'b0;
    while (report_queue.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    win_len      = len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Result side: random stalls except in the calm phase, compare at the rising edge.
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= calm ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (report_queue.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("report beat with none expected: %h", got);
      end else begin
        report_t want;
        want = report_queue.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("report mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      watch <= 0;
    end else begin
      watch <= watch + 1;
      if (watch == WatchLimit) begin
        $display("completion_stats_monitor_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic random_record(logic [31:0] span);
    logic [31:0] now;
    logic [31:0] arrived;
    logic [31:0] job;
    int          pick;
    pick = $urandom_range(0, 19);
    now = (pick == 0) ? $urandom : $urandom_range(0, span);
    arrived = (pick == 1) ? $urandom : (now == 0 ? 32'd0 : $urandom_range(0, now));
    case ($urandom_range(0, 5))
      0:       job = 32'd0;
      1:       job = $urandom;
      2:       job = 32'd1;
      default: job = $urandom_range(1, 500);
    endcase
    send_beat(CmdRecord, now, arrived, job, 1'b0, '0);
  endtask

  initial begin
    stim_row_t rows [$];
    report_t   empty_rep;
    logic [31:0] span;
    empty_rep = '0;
    empty_rep.no_data = 1'b1;
    for (int i = 0; i < Windows; i++) win_hist[i] = '0;
    turn_total = '0; ovh_total = '0; ovh_peak = '0; done_count = '0;
    win_len = WindowLengthReset;

    // Directed table: empty report first, then field extremes and special cases.
    rows.push_back('{CmdReport, 32'hFFFF_FFFF, '0, '0, 1'b1, empty_rep});
    rows.push_back('{CmdRecord, 32'd0, 32'd0, 32'd1, 1'b0, '0});
    rows.push_back('{CmdRecord, 32'd60, 32'd0, 32'd60, 1'b0, '0});
    rows.push_back('{CmdRecord, 32'd61, 32'd0, 32'd0, 1'b0, '0});
    rows.push_back('{CmdRecord, 32'd10, 32'd50, 32'd5, 1'b0, '0});
    rows.push_back('{CmdRecord, 32'hFFFF_FFFF, 32'd0, 32'd1, 1'b0, '0});
    rows.push_back('{CmdRecord, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0});
    rows.push_back('{CmdRecord, 32'd200, 32'd100, 32'd3, 1'b0, '0});
    rows.push_back('{CmdReport, 32'd0, '0, '0, 1'b0, '0});
    rows.push_back('{CmdRecord, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0});
    rows.push_back('{CmdRecord, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0});
    rows.push_back('{CmdReport, 32'h1234_5678, '0, '0, 1'b0, '0});

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i])
      send_beat(rows[i].cmd, rows[i].now, rows[i].arrived, rows[i].job,
                rows[i].typed, rows[i].want);

    // Sender holds off until every report is back, then sets a window length of one.
    drain_and_write(16'd1);
    for (int k = 0; k < 40; k++) random_record(32'd300);
    send_beat(CmdReport, $urandom, '0, '0, 1'b0, '0);

    // Random phases over several window lengths, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: drain_and_write(16'hFFFF);
        1: drain_and_write(16'd0);
        2: drain_and_write(16'd7);
        3: drain_and_write(16'hA5A5);
        4: drain_and_write(16'h5A5A);
        default: drain_and_write(16'd60);
      endcase
      span = {16'd0, (win_len == 0 ? 16'd1 : win_len)} * (Windows + 4);
      if (ph == 5) calm = 1'b1;
      for (int k = 0; k < RandomBeats / 6; k++) begin
        if ($urandom_range(0, 11) == 0) send_beat(CmdReport, $urandom, '0, '0, 1'b0, '0);
        else random_record(span);
      end
      send_beat(CmdReport, $urandom, '0, '0, 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (report_queue.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("completion_stats_monitor_tb OK");
    end else begin
      $display("completion_stats_monitor_tb NOT OK");
    end
    $finish;
  end

endmodule
